// ===== hw/rtl/sarc_pkg.sv =====
// Shared types and constants for the set-associative search result cache.
package sarc_pkg;

    localparam int SET_INDEX_BITS = 10;
    localparam int WAYS           = 4;
    localparam int WAY_BITS       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_COUNT      = 1 << SET_INDEX_BITS;

    localparam logic [1:0] BOUND_EMPTY = 2'd0;
    localparam logic       FUNC_PROBE  = 1'b0;
    localparam logic       FUNC_STORE  = 1'b1;

    typedef struct packed {
        logic [7:0] age;
        logic [1:0] bound;
        logic [7:0] depth;
    } meta_t;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] move;
        logic [31:0] score;
        meta_t       meta;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    // Outcome of scanning one set.
    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] hit_way;
        logic [WAY_BITS-1:0] store_way;
    } way_sel_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

endpackage

// ===== hw/rtl/sarc_row_ram.sv =====
// Generic single-port-write, registered-read RAM holding one set per row.
module sarc_row_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 584
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/sarc_set_select.sv =====
// Way selection for one set: probe hit search and store target choice.
module sarc_set_select (
    input  sarc_pkg::row_t     row,
    input  logic [63:0]        key,
    output sarc_pkg::way_sel_t sel
);
    import sarc_pkg::*;

    logic [WAY_BITS-1:0] hit_way;
    logic                hit_any;
    logic [WAY_BITS-1:0] free_way;
    logic                free_any;
    logic [WAY_BITS-1:0] victim_way;
    logic [15:0]         victim_rank;

    // Lowest-numbered way wins both searches, so scan from the top down.
    always_comb
    begin
        hit_way  = '0;
        hit_any  = 1'b0;
        free_way = '0;
        free_any = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row[w].meta.bound != BOUND_EMPTY && row[w].key == key)
            begin
                hit_way = WAY_BITS'(w);
                hit_any = 1'b1;
            end
            if (row[w].key == key || row[w].meta.bound == BOUND_EMPTY)
            begin
                free_way = WAY_BITS'(w);
                free_any = 1'b1;
            end
        end
    end

    // Replacement victim: least depth, then least age; earlier way on a full tie.
    always_comb
    begin
        victim_way  = '0;
        victim_rank = {row[0].meta.depth, row[0].meta.age};
        for (int w = 1; w < WAYS; w++)
        begin
            if ({row[w].meta.depth, row[w].meta.age} < victim_rank)
            begin
                victim_way  = WAY_BITS'(w);
                victim_rank = {row[w].meta.depth, row[w].meta.age};
            end
        end
    end

    assign sel.hit       = hit_any;
    assign sel.hit_way   = hit_way;
    assign sel.store_way = free_any ? free_way : victim_way;

endmodule

// ===== hw/rtl/set_assoc_search_result_cache.sv =====
// Top level of the set-associative search result cache.
//
// The block caches search results keyed by a 64-bit position hash. The low
// SET_INDEX_BITS bits of the key pick a set of WAYS entries, all held in one
// row of a synchronous RAM. A command transaction is accepted at a rising
// edge where start is high and busy is low; func selects a probe or a store.
// At acceptance the set row is read. In the following cycle the row is
// scanned, and for a store with a bound other than empty the chosen way is
// merged in and the row written back. The result is registered at the end
// of the scan and shown on the result ports, marked by done, which is high
// for exactly one cycle. Every transaction gives one result; a store and a
// probe miss return hit low and all fields 0. Busy stays high during the
// scan, so a new command is taken only once the previous one has been
// scanned and, for a store, written back. Since the write-back completes
// before the next read is issued, back-to-back commands on the same set
// need no forwarding. The receiver cannot stall: done is a strobe.
// After reset the block sweeps the RAM once, one row per cycle, writing
// empty entries; busy stays high until all 2^SET_INDEX_BITS (1024) rows
// are written. The generation register (cfg_we, cfg_data) is stamped into
// every stored entry during the scan, so the user must write it only while
// no transaction is in flight; the block itself does not enforce this.
module set_assoc_search_result_cache (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [63:0]        key,
    input  logic [31:0]        move_in,
    input  logic signed [31:0] score_in,
    input  logic [7:0]         depth_in,
    input  logic [1:0]         bound_in,
    output logic               done,
    output logic               hit,
    output logic [31:0]        move_out,
    output logic signed [31:0] score_out,
    output logic [7:0]         depth_out,
    output logic [1:0]         bound_out,
    output logic [7:0]         age_out
);
    import sarc_pkg::*;

    state_t                    state_reg, state_next;
    logic [SET_INDEX_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]                gen_reg;

    // Command captured at acceptance.
    logic                      func_reg;
    logic [63:0]               key_reg;
    logic [31:0]               move_reg;
    logic [31:0]               score_reg;
    logic [7:0]                depth_reg;
    logic [1:0]                bound_reg;

    // Result registers.
    logic                      done_reg;
    logic                      hit_reg;
    logic [31:0]               move_out_reg;
    logic [31:0]               score_out_reg;
    logic [7:0]                depth_out_reg;
    logic [1:0]                bound_out_reg;
    logic [7:0]                age_out_reg;

    logic                      accept;
    row_t                      rd_row;
    row_t                      wr_row;
    logic                      ram_we;
    logic [SET_INDEX_BITS-1:0] ram_waddr;
    way_sel_t                  sel;
    entry_t                    new_entry;
    entry_t                    hit_entry;
    logic                      probe_hit;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    sarc_row_ram #(
        .ADDR_BITS (SET_INDEX_BITS),
        .DATA_BITS ($bits(row_t))
    ) u_row_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (key[SET_INDEX_BITS-1:0]),
        .rd_data (rd_row),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (wr_row)
    );

    sarc_set_select u_set_select (
        .row (rd_row),
        .key (key_reg),
        .sel (sel)
    );

    // Entry built from the captured command.
    always_comb
    begin
        new_entry.key        = key_reg;
        new_entry.move       = move_reg;
        new_entry.score      = score_reg;
        new_entry.meta.age   = gen_reg;
        new_entry.meta.bound = bound_reg;
        new_entry.meta.depth = depth_reg;
    end

    // The clearing sweep writes empty rows; a store merges its entry into the
    // row that was read. A store with bound none leaves the set untouched.
    always_comb
    begin
        wr_row    = rd_row;
        ram_we    = 1'b0;
        ram_waddr = key_reg[SET_INDEX_BITS-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                wr_row    = '0;
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            ST_LOOKUP:
            begin
                wr_row[sel.store_way] = new_entry;
                ram_we = (func_reg == FUNC_STORE) && (bound_reg != BOUND_EMPTY);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign hit_entry = rd_row[sel.hit_way];
    assign probe_hit = (func_reg == FUNC_PROBE) && sel.hit;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {SET_INDEX_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            gen_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == ST_LOOKUP);
            if (cfg_we)
            begin
                gen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            key_reg   <= key;
            move_reg  <= move_in;
            score_reg <= score_in;
            depth_reg <= depth_in;
            bound_reg <= bound_in;
        end
        if (state_reg == ST_LOOKUP)
        begin
            hit_reg       <= probe_hit;
            move_out_reg  <= probe_hit ? hit_entry.move       : '0;
            score_out_reg <= probe_hit ? hit_entry.score      : '0;
            depth_out_reg <= probe_hit ? hit_entry.meta.depth : '0;
            bound_out_reg <= probe_hit ? hit_entry.meta.bound : '0;
            age_out_reg   <= probe_hit ? hit_entry.meta.age   : '0;
        end
    end

    assign done      = done_reg;
    assign hit       = done_reg & hit_reg;
    assign move_out  = move_out_reg;
    assign score_out = score_out_reg;
    assign depth_out = depth_out_reg;
    assign bound_out = bound_out_reg;
    assign age_out   = age_out_reg;

    // An accepted command always moves on to the set scan.
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted command did not enter the set scan");

    // Every scan is followed by a result strobe.
    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |=> done)
        else $error("set scan produced no result strobe");

    a_done_only_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_LOOKUP))
        else $error("result strobe without a preceding set scan");

    // The RAM is never written while the block is idle.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != ST_IDLE))
        else $error("RAM written while idle");

    // A hit is only reported for a probe.
    a_hit_from_probe: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (func_reg == FUNC_PROBE))
        else $error("hit reported for a store");

endmodule

// ===== verif/set_assoc_search_result_cache_check.sv =====
// Checker for the search result cache: shadow table, result prediction and comparison.
`timescale 1ns / 1ps

module set_assoc_search_result_cache_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               start,
    input  logic               busy,
    input  logic               func,
    input  logic [63:0]        key,
    input  logic [31:0]        move_in,
    input  logic signed [31:0] score_in,
    input  logic [7:0]         depth_in,
    input  logic [1:0]         bound_in,
    input  logic               done,
    input  logic               hit,
    input  logic [31:0]        move_out,
    input  logic signed [31:0] score_out,
    input  logic [7:0]         depth_out,
    input  logic [1:0]         bound_out,
    input  logic [7:0]         age_out,
    output int                 mismatch_count,
    output int                 pending_count
);
    import sarc_pkg::*;

    localparam int ENTRY_TOTAL = SET_COUNT * WAYS;

    typedef struct packed {
        logic        hit;
        logic [31:0] move;
        logic [31:0] score;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic [7:0]  age;
    } answer_t;

    entry_t     shadow_entries [ENTRY_TOTAL];
    logic [7:0] shadow_generation;
    answer_t    pending_answers [$];
    answer_t    oldest_answer;

    // Applies one command to the shadow table and returns the answer it must give.
    function automatic answer_t lookup_and_update(input logic f, input logic [63:0] k,
                                                  input logic [31:0] mv, input logic [31:0] sc,
                                                  input logic [7:0] d, input logic [1:0] b);
        answer_t ans;
        int      base;
        int      target;
        logic    found;
        ans    = '0;
        base   = int'(k[SET_INDEX_BITS-1:0]) * WAYS;
        found  = 1'b0;
        target = base;
        if (f == FUNC_PROBE)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (!found && shadow_entries[base+w].meta.bound != BOUND_EMPTY &&
                    shadow_entries[base+w].key == k)
                begin
                    found     = 1'b1;
                    ans.hit   = 1'b1;
                    ans.move  = shadow_entries[base+w].move;
                    ans.score = shadow_entries[base+w].score;
                    ans.depth = shadow_entries[base+w].meta.depth;
                    ans.bound = shadow_entries[base+w].meta.bound;
                    ans.age   = shadow_entries[base+w].meta.age;
                end
            end
            return ans;
        end
        // A store with an empty bound leaves the table untouched.
        if (b == BOUND_EMPTY)
            return ans;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && (shadow_entries[base+w].key == k ||
                           shadow_entries[base+w].meta.bound == BOUND_EMPTY))
            begin
                found  = 1'b1;
                target = base + w;
            end
        end
        if (!found)
        begin
            // Shallowest entry goes; on equal depth the smaller stamp, then the lower way.
            for (int w = 0; w < WAYS; w++)
            begin
                if (shadow_entries[base+w].meta.depth < shadow_entries[target].meta.depth)
                    target = base + w;
                else if (shadow_entries[base+w].meta.depth ==
                         shadow_entries[target].meta.depth &&
                         shadow_entries[base+w].meta.age < shadow_entries[target].meta.age)
                    target = base + w;
            end
        end
        shadow_entries[target].key        = k;
        shadow_entries[target].move       = mv;
        shadow_entries[target].score      = sc;
        shadow_entries[target].meta.depth = d;
        shadow_entries[target].meta.bound = b;
        shadow_entries[target].meta.age   = shadow_generation;
        return ans;
    endfunction

    task automatic report_mismatch(input string why, input answer_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%t mismatch (%s): expected hit=%0d move=%h score=%h depth=%0d",
                     $realtime, why, want.hit, want.move, want.score, want.depth,
                     " bound=%0d age=%0d", want.bound, want.age);
            $display("    got hit=%0d move=%h score=%h depth=%0d bound=%0d age=%0d",
                     hit, move_out, score_out, depth_out, bound_out, age_out);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_TOTAL; i++)
                shadow_entries[i] = '0;
            shadow_generation = 8'd0;
            pending_answers.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch("result with nothing outstanding", '0);
                else
                begin
                    oldest_answer = pending_answers.pop_front();
                    if (hit !== oldest_answer.hit || move_out !== oldest_answer.move ||
                        score_out !== oldest_answer.score || depth_out !== oldest_answer.depth ||
                        bound_out !== oldest_answer.bound || age_out !== oldest_answer.age)
                        report_mismatch("field differs", oldest_answer);
                end
            end
            if (cfg_we)
                shadow_generation = cfg_data;
            if (start && !busy)
                pending_answers.push_back(lookup_and_update(func, key, move_in, score_in,
                                                            depth_in, bound_in));
            pending_count = pending_answers.size();
        end
    end

endmodule

// ===== verif/set_assoc_search_result_cache_test.sv =====
// Testbench top for the search result cache: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module set_assoc_search_result_cache_test;

    import sarc_pkg::*;

    // A run with no accepted transaction and no result for this many cycles is hung.
    // The clearing sweep after reset alone keeps busy high until every set is cleared.
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int SEGMENT_COUNT    = 12;
    localparam int SEGMENT_ITEMS    = 128;
    localparam int HOT_SET_COUNT    = 6;
    localparam int TAGS_PER_SET     = 6;
    localparam int TAG_BITS         = 64 - SET_INDEX_BITS;
    localparam logic [SET_INDEX_BITS-1:0] DIRECTED_SET = SET_INDEX_BITS'(5);

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [7:0]         cfg_data = 8'd0;
    logic               start    = 1'b0;
    logic               busy;
    logic               func     = FUNC_PROBE;
    logic [63:0]        key      = 64'd0;
    logic [31:0]        move_in  = 32'd0;
    logic signed [31:0] score_in = 32'sd0;
    logic [7:0]         depth_in = 8'd0;
    logic [1:0]         bound_in = BOUND_EMPTY;
    logic               done;
    logic               hit;
    logic [31:0]        move_out;
    logic signed [31:0] score_out;
    logic [7:0]         depth_out;
    logic [1:0]         bound_out;
    logic [7:0]         age_out;

    int mismatch_count;
    int pending_count;

    // Chance in percent that the sender leaves a cycle empty before a transaction.
    int idle_pct = 0;

    // A few sets with a handful of tags each are hammered, so that sets fill up,
    // probes hit, stores update entries in place and replacement is exercised.
    logic [SET_INDEX_BITS-1:0] hot_sets [HOT_SET_COUNT];
    logic [TAG_BITS-1:0]       hot_tags [HOT_SET_COUNT][TAGS_PER_SET];

    set_assoc_search_result_cache i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .key       (key),
        .move_in   (move_in),
        .score_in  (score_in),
        .depth_in  (depth_in),
        .bound_in  (bound_in),
        .done      (done),
        .hit       (hit),
        .move_out  (move_out),
        .score_out (score_out),
        .depth_out (depth_out),
        .bound_out (bound_out),
        .age_out   (age_out)
    );

    set_assoc_search_result_cache_check i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .key            (key),
        .move_in        (move_in),
        .score_in       (score_in),
        .depth_in       (depth_in),
        .bound_in       (bound_in),
        .done           (done),
        .hit            (hit),
        .move_out       (move_out),
        .score_out      (score_out),
        .depth_out      (depth_out),
        .bound_out      (bound_out),
        .age_out        (age_out),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Builds a key whose low bits pick the given set and whose upper bits are the tag.
    function automatic logic [63:0] compose_key(input logic [TAG_BITS-1:0] tag,
                                                input logic [SET_INDEX_BITS-1:0] set_idx);
        return {tag, set_idx};
    endfunction

    // Key with a small tag in the set used by the directed part.
    function automatic logic [63:0] directed_key(input int tag);
        return compose_key(TAG_BITS'(tag), DIRECTED_SET);
    endfunction

    // Offers one command transaction and returns once it has been accepted. Inputs
    // change at the falling edge only. When no idle cycle is inserted, start stays
    // high and the next transaction follows right behind this one.
    task automatic issue(input logic f, input logic [63:0] k, input logic [31:0] mv,
                         input logic [31:0] sc, input logic [7:0] d, input logic [1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            // Idle cycles carry random garbage on the payload to show it is ignored.
            start    <= 1'b0;
            func     <= 1'($urandom_range(1));
            key      <= {$urandom, $urandom};
            move_in  <= $urandom;
            score_in <= $urandom;
            depth_in <= 8'($urandom);
            bound_in <= 2'($urandom);
        end
        @(negedge clk);
        start    <= 1'b1;
        func     <= f;
        key      <= k;
        move_in  <= mv;
        score_in <= sc;
        depth_in <= d;
        bound_in <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // A probe still carries random payload fields, which the block must ignore.
    task automatic probe(input logic [63:0] k);
        issue(FUNC_PROBE, k, $urandom, $urandom, 8'($urandom), 2'($urandom));
    endtask

    // Stops the sender and waits until every outstanding result has come back.
    // The block is idle afterwards, so the generation register may be rewritten.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_generation(input logic [7:0] gen);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= gen;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_data <= 8'($urandom);
    endtask

    // One random command: mostly keys from the hot sets with shallow depths so
    // that depth ties are frequent, plus some keys scattered over the whole table.
    task automatic random_transaction();
        logic [63:0] k;
        logic [7:0]  d;
        logic [1:0]  b;
        int          si;
        si = $urandom_range(HOT_SET_COUNT - 1);
        if ($urandom_range(99) < 85)
            k = compose_key(hot_tags[si][$urandom_range(TAGS_PER_SET - 1)], hot_sets[si]);
        else
            k = {$urandom, $urandom};
        d = ($urandom_range(99) < 75) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        b = ($urandom_range(99) < 10) ? BOUND_EMPTY : 2'($urandom_range(3, 1));
        issue(1'($urandom_range(1)), k, $urandom, $urandom, d, b);
    endtask

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("set_assoc_search_result_cache_test NOT OK");
        $finish;
    end

    initial
    begin
        logic [7:0]  gen;
        logic [63:0] rnd_bits;
        for (int s = 0; s < HOT_SET_COUNT; s++)
        begin
            hot_sets[s] = SET_INDEX_BITS'($urandom);
            for (int t = 0; t < TAGS_PER_SET; t++)
            begin
                rnd_bits       = {$urandom, $urandom};
                hot_tags[s][t] = rnd_bits[63:SET_INDEX_BITS];
            end
        end

        // Reset is held at the start; afterwards the block clears its table and
        // keeps busy high until the sweep has finished.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);

        // Directed part, back to back. Key zero and the all-ones key sit in the
        // first and last set and must miss on the freshly cleared table.
        write_generation(8'd255);
        probe(64'd0);
        probe({64{1'b1}});
        issue(FUNC_STORE, {64{1'b1}}, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'd255, 2'd3);
        probe({64{1'b1}});
        issue(FUNC_STORE, 64'd0, 32'd0, 32'h8000_0000, 8'd0, 2'd1);
        probe(64'd0);
        // A store whose bound is empty must leave the table unchanged.
        issue(FUNC_STORE, directed_key(7), $urandom, $urandom, 8'd4, BOUND_EMPTY);
        probe(directed_key(7));

        // Fill one set: three entries of equal depth, the first with a larger stamp, and a deeper one.
        drain_results();
        write_generation(8'd10);
        issue(FUNC_STORE, directed_key(1), $urandom, $urandom, 8'd3, 2'd2);
        drain_results();
        write_generation(8'd5);
        issue(FUNC_STORE, directed_key(2), $urandom, $urandom, 8'd3, 2'd1);
        issue(FUNC_STORE, directed_key(3), $urandom, $urandom, 8'd3, 2'd3);
        issue(FUNC_STORE, directed_key(4), $urandom, $urandom, 8'd9, 2'd2);
        // The set is full: the older of the shallowest entries goes, and of the two
        // tied on both depth and stamp the lower way is replaced.
        issue(FUNC_STORE, directed_key(5), $urandom, $urandom, 8'd6, 2'd1);
        probe(directed_key(2));
        probe(directed_key(3));
        probe(directed_key(5));
        // Rewriting an existing key updates it in place, here making it the shallowest.
        issue(FUNC_STORE, directed_key(3), $urandom, $urandom, 8'd0, 2'd2);
        issue(FUNC_STORE, directed_key(6), $urandom, $urandom, 8'd200, 2'd3);
        probe(directed_key(3));
        probe(directed_key(6));

        // Random part in segments. Each segment starts from an idle block with a
        // new generation, so stamps in a set differ and age tie-breaks matter. The
        // sender idles lightly first, then heavily, then not at all.
        for (int seg = 0; seg < SEGMENT_COUNT; seg++)
        begin
            drain_results();
            if (seg == 0)
                gen = 8'd0;
            else if (seg == 1)
                gen = 8'd255;
            else
                gen = 8'($urandom_range(255));
            write_generation(gen);
            if (seg < SEGMENT_COUNT / 3)
                idle_pct = 10;
            else if (seg < 2 * SEGMENT_COUNT / 3)
                idle_pct = 57;
            else
                idle_pct = 0;
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                random_transaction();
        end

        // Let the last results come back, then wait longer for any stray ones.
        drain_results();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("set_assoc_search_result_cache_test OK");
        else
            $display("set_assoc_search_result_cache_test NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sarc_pkg.sv
hw/rtl/sarc_row_ram.sv
hw/rtl/sarc_set_select.sv
hw/rtl/set_assoc_search_result_cache.sv
verif/set_assoc_search_result_cache_check.sv
verif/set_assoc_search_result_cache_test.sv
